// ===== sv/q4kbd_pkg.sv =====
// Shared types, constants and helper functions for the Q4_K block dequantizer.
`timescale 1ns / 1ps
package q4kbd_pkg;

    localparam logic [7:0]  BLOCK_LAST   = 8'd143;
    localparam logic [7:0]  HEADER_BYTES = 8'd16;
    localparam logic [31:0] CANON_NAN    = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_TOP      = 8'd152;

    typedef logic [15:0][7:0] hdr_t;

    // One nibble byte with everything the back end needs to finish it.
    typedef struct packed {
        logic [30:0] base;
        logic [7:0]  qbyte;
        logic [5:0]  sc0;
        logic [5:0]  mn0;
        logic [5:0]  sc1;
        logic [5:0]  mn1;
        logic [15:0] d_bits;
        logic [15:0] dm_bits;
        logic [1:0]  emit;
    } fe_item_t;

    // A half-precision value as integer mantissa times 2^(sh-24).
    typedef struct packed {
        logic        sgn;
        logic        inf;
        logic        nan;
        logic [10:0] mant;
        logic [4:0]  sh;
    } half_t;

    function automatic half_t half_decode(logic [15:0] h);
        half_t r;
        r.sgn  = h[15];
        r.inf  = 1'b0;
        r.nan  = 1'b0;
        r.mant = {1'b1, h[9:0]};
        r.sh   = h[14:10] - 5'd1;
        if (h[14:10] == 5'd0) begin
            r.mant = {1'b0, h[9:0]};
            r.sh   = 5'd0;
        end else if (h[14:10] == 5'd31) begin
            r.inf  = (h[9:0] == 10'd0);
            r.nan  = (h[9:0] != 10'd0);
            r.mant = 11'd0;
            r.sh   = 5'd0;
        end
        return r;
    endfunction

    // 6-bit scale of pair j from the packed header bytes 4..15.
    function automatic logic [5:0] pair_sc(hdr_t h, logic [2:0] j);
        logic [3:0] a;
        logic [3:0] c;
        a = 4'd4 + {2'b00, j[1:0]};
        c = 4'd12 + {2'b00, j[1:0]};
        if (!j[2]) begin
            return h[a][5:0];
        end
        return {h[a][7:6], h[c][3:0]};
    endfunction

    // 6-bit minimum of pair j from the packed header bytes 4..15.
    function automatic logic [5:0] pair_mn(hdr_t h, logic [2:0] j);
        logic [3:0] b;
        logic [3:0] c;
        b = 4'd8 + {2'b00, j[1:0]};
        c = 4'd12 + {2'b00, j[1:0]};
        if (!j[2]) begin
            return h[b][5:0];
        end
        return {h[b][7:6], h[c][7:4]};
    endfunction

    // Leading zeros of a 25-bit word; 25 when the word is zero.
    function automatic logic [4:0] lz25(logic [24:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd25;
        found = 1'b0;
        for (int i = 24; i >= 0; i--) begin
            if (v[i] && !found) begin
                n = 5'(24 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ===== sv/q4k_block_dequantizer.sv =====
// Each kept element of a nibble byte passes the queue and the back end's pipeline registers.
// Throughput: one element per cycle unless the output stalls; a nibble byte with both
// elements kept is issued low then high by the single shared arithmetic pipeline
// fed from the two-entry byte queue. Header bytes are stored and produce no elements.
// Reset (rst_n, asynchronous, active low) clears the block position, block count,
// element limit, queue and pipeline; header bytes are undefined until the stream writes them.
`timescale 1ns / 1ps
module q4k_block_dequantizer
    import q4kbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: the element limit, written whenever cfg_wr_en is high.
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,
    // Input stream of block bytes.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    // Result stream of dequantized elements.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [30:0] elem_index,
    output logic [31:0] value_bits,
    output logic        run_last
);

    logic [30:0] total_reg;
    logic        fifo_full;
    logic        push;
    fe_item_t    push_item;
    logic        pop;
    logic        head_valid;
    fe_item_t    head;

    // The element limit only moves on configuration transactions.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            total_reg <= 31'd0;
        end else if (cfg_wr_en) begin
            total_reg <= cfg_wr_data;
        end
    end

    // The front end consumes one byte per transaction. Header bytes are stored in
    // place; nibble bytes are tagged with their scales and which elements survive
    // the limit, then queued. Bytes with no surviving element are dropped here.
    q4kbd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .total_elements (total_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .fifo_full      (fifo_full),
        .push           (push),
        .push_item      (push_item)
    );

    // The queue lets header bytes keep flowing while the back end is stalled.
    q4kbd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // The back end splits each entry into its low and high elements and computes
    // scale*sc*q - min*m exactly in fixed point before one rounding to fp32.
    q4kbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .elem_index (elem_index),
        .value_bits (value_bits),
        .run_last   (run_last)
    );

endmodule

// ===== sv/q4kbd_fifo.sv =====
// Two-entry queue between the byte front end and the arithmetic back end.
`timescale 1ns / 1ps
module q4kbd_fifo
    import q4kbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  fe_item_t push_item,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output fe_item_t head
);

    fe_item_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

endmodule

// ===== sv/q4kbd_front.sv =====
// Front end: tracks the place in the block, keeps the header and queues nibble bytes.
`timescale 1ns / 1ps
module q4kbd_front
    import q4kbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [30:0] total_elements,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        fifo_full,
    output logic        push,
    output fe_item_t    push_item
);

    logic [7:0]  pos_reg;
    logic [7:0]  pos_next;
    logic [23:0] blk_reg;
    logic [23:0] blk_next;
    hdr_t        hdr_reg;
    logic        is_hdr;
    logic        accept;
    logic [7:0]  t;
    logic [1:0]  g;
    logic [31:0] idx_lo;
    logic [31:0] idx_hi;
    logic [1:0]  emit;

    assign is_hdr   = (pos_reg < HEADER_BYTES);
    assign in_ready = is_hdr || !fifo_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        t      = pos_reg - HEADER_BYTES;
        g      = t[6:5];
        idx_lo = {blk_reg, g, 1'b0, t[4:0]};
        idx_hi = {blk_reg, g, 1'b1, t[4:0]};
        emit   = {idx_hi < {1'b0, total_elements}, idx_lo < {1'b0, total_elements}};

        push_item.base    = idx_lo[30:0];
        push_item.qbyte   = data_byte;
        push_item.sc0     = pair_sc(hdr_reg, {g, 1'b0});
        push_item.mn0     = pair_mn(hdr_reg, {g, 1'b0});
        push_item.sc1     = pair_sc(hdr_reg, {g, 1'b1});
        push_item.mn1     = pair_mn(hdr_reg, {g, 1'b1});
        push_item.d_bits  = {hdr_reg[1], hdr_reg[0]};
        push_item.dm_bits = {hdr_reg[3], hdr_reg[2]};
        push_item.emit    = emit;

        push = accept && !is_hdr && (emit != 2'b00);

        pos_next = pos_reg + 8'd1;
        blk_next = blk_reg;
        if (pos_reg == BLOCK_LAST) begin
            pos_next = 8'd0;
            blk_next = blk_reg + 24'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_hdr) begin
            hdr_reg[pos_reg[3:0]] <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= 8'd0;
            blk_reg <= 24'd0;
        end else if (accept) begin
            pos_reg <= pos_next;
            blk_reg <= blk_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= BLOCK_LAST)
        else $error("byte position left the block");

endmodule

// ===== sv/q4kbd_back.sv =====
// Back end: issues one element per cycle unless stalled; six stages compute it.
`timescale 1ns / 1ps
module q4kbd_back
    import q4kbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  fe_item_t    head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [30:0] elem_index,
    output logic [31:0] value_bits,
    output logic        run_last
);

    logic en;
    logic take;
    logic sel_hi;
    logic phase_reg;
    logic phase_next;

    // Stage 1: operands decoded, scale products formed.
    logic        v1_reg, last1_reg, scz1_reg, mnz1_reg;
    logic [30:0] idx1_reg;
    logic [3:0]  q1_reg;
    half_t       hd1_reg, hm1_reg;
    logic [16:0] pd1_reg, pm1_reg;
    // Stage 2: product with the quant, special cases resolved.
    logic        v2_reg, last2_reg, sd2_reg, sm2_reg, spec2_reg;
    logic [30:0] idx2_reg;
    logic [20:0] pmag2_reg;
    logic [16:0] bmag2_reg;
    logic [4:0]  shd2_reg, shm2_reg;
    logic [31:0] sbits2_reg;
    // Stage 3: aligned subtraction.
    logic        v3_reg, last3_reg, spec3_reg, sgn3_reg, zsgn3_reg;
    logic [30:0] idx3_reg;
    logic [31:0] sbits3_reg;
    logic [49:0] mag3_reg;
    // Stage 4: leading-zero count per half.
    logic        v4_reg, last4_reg, spec4_reg, sgn4_reg, zsgn4_reg, hiz4_reg;
    logic [30:0] idx4_reg;
    logic [31:0] sbits4_reg;
    logic [49:0] mag4_reg;
    logic [4:0]  hlz4_reg, llz4_reg;
    // Stage 5: normalized.
    logic        v5_reg, last5_reg, spec5_reg, sgn5_reg, zsgn5_reg, zero5_reg;
    logic [30:0] idx5_reg;
    logic [31:0] sbits5_reg;
    logic [49:0] norm5_reg;
    logic [7:0]  exp5_reg;
    // Stage 6: rounded result, the output register.
    logic        v6_reg, last6_reg;
    logic [30:0] idx6_reg;
    logic [31:0] val6_reg;

    half_t       hd_next, hm_next;
    logic [5:0]  sc_next, mn_next;
    logic [3:0]  q_next;
    logic        p_nan, p_inf, b_nan, b_inf;
    logic [31:0] sbits_next;
    logic [49:0] pa, ba, mag_next;
    logic        sgn_next;
    logic [5:0]  lz;
    logic [31:0] rounded;
    logic        rnd;
    logic [31:0] val_next;

    assign en     = !v6_reg || out_ready;
    assign take   = head_valid && en;
    assign sel_hi = phase_reg || !head.emit[0];
    assign pop    = take && (sel_hi || !head.emit[1]);

    always_comb
    begin
        phase_next = phase_reg;
        if (take) begin
            phase_next = !sel_hi && head.emit[1];
        end
        hd_next = half_decode(head.d_bits);
        hm_next = half_decode(head.dm_bits);
        sc_next = sel_hi ? head.sc1 : head.sc0;
        mn_next = sel_hi ? head.mn1 : head.mn0;
        q_next  = sel_hi ? head.qbyte[7:4] : head.qbyte[3:0];

        p_nan = hd1_reg.nan || (hd1_reg.inf && (scz1_reg || q1_reg == 4'd0));
        p_inf = hd1_reg.inf && !p_nan;
        b_nan = hm1_reg.nan || (hm1_reg.inf && mnz1_reg);
        b_inf = hm1_reg.inf && !b_nan;
        if (p_nan || b_nan || (p_inf && b_inf && hd1_reg.sgn == hm1_reg.sgn)) begin
            sbits_next = CANON_NAN;
        end else if (p_inf) begin
            sbits_next = {hd1_reg.sgn, 8'hFF, 23'd0};
        end else begin
            sbits_next = {~hm1_reg.sgn, 8'hFF, 23'd0};
        end

        pa = {29'd0, pmag2_reg} << shd2_reg;
        ba = {33'd0, bmag2_reg} << shm2_reg;
        if (sd2_reg != sm2_reg) begin
            mag_next = pa + ba;
            sgn_next = sd2_reg;
        end else if (pa >= ba) begin
            mag_next = pa - ba;
            sgn_next = sd2_reg;
        end else begin
            mag_next = ba - pa;
            sgn_next = !sd2_reg;
        end

        lz = hiz4_reg ? (6'd25 + {1'b0, llz4_reg}) : {1'b0, hlz4_reg};

        rnd     = norm5_reg[25] && (norm5_reg[26] || (norm5_reg[24:0] != 25'd0));
        rounded = {sgn5_reg, exp5_reg, norm5_reg[48:26]} + {31'd0, rnd};
        if (spec5_reg) begin
            val_next = sbits5_reg;
        end else if (zero5_reg) begin
            val_next = {zsgn5_reg, 31'd0};
        end else begin
            val_next = rounded;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            idx1_reg  <= sel_hi ? {head.base[30:6], 1'b1, head.base[4:0]} : head.base;
            last1_reg <= sel_hi || !head.emit[1];
            q1_reg    <= q_next;
            scz1_reg  <= (sc_next == 6'd0);
            mnz1_reg  <= (mn_next == 6'd0);
            hd1_reg   <= hd_next;
            hm1_reg   <= hm_next;
            pd1_reg   <= {6'd0, hd_next.mant} * {11'd0, sc_next};
            pm1_reg   <= {6'd0, hm_next.mant} * {11'd0, mn_next};

            idx2_reg   <= idx1_reg;
            last2_reg  <= last1_reg;
            pmag2_reg  <= {4'd0, pd1_reg} * {17'd0, q1_reg};
            bmag2_reg  <= pm1_reg;
            shd2_reg   <= hd1_reg.sh;
            shm2_reg   <= hm1_reg.sh;
            sd2_reg    <= hd1_reg.sgn;
            sm2_reg    <= hm1_reg.sgn;
            spec2_reg  <= p_nan || p_inf || b_nan || b_inf;
            sbits2_reg <= sbits_next;

            idx3_reg   <= idx2_reg;
            last3_reg  <= last2_reg;
            spec3_reg  <= spec2_reg;
            sbits3_reg <= sbits2_reg;
            mag3_reg   <= mag_next;
            sgn3_reg   <= sgn_next;
            zsgn3_reg  <= sd2_reg && !sm2_reg;

            idx4_reg   <= idx3_reg;
            last4_reg  <= last3_reg;
            spec4_reg  <= spec3_reg;
            sbits4_reg <= sbits3_reg;
            mag4_reg   <= mag3_reg;
            sgn4_reg   <= sgn3_reg;
            zsgn4_reg  <= zsgn3_reg;
            hlz4_reg   <= lz25(mag3_reg[49:25]);
            llz4_reg   <= lz25(mag3_reg[24:0]);
            hiz4_reg   <= (mag3_reg[49:25] == 25'd0);

            idx5_reg   <= idx4_reg;
            last5_reg  <= last4_reg;
            spec5_reg  <= spec4_reg;
            sbits5_reg <= sbits4_reg;
            sgn5_reg   <= sgn4_reg;
            zsgn5_reg  <= zsgn4_reg;
            zero5_reg  <= (mag4_reg == 50'd0);
            norm5_reg  <= mag4_reg << lz;
            exp5_reg   <= EXP_TOP - {2'b00, lz};

            idx6_reg  <= idx5_reg;
            last6_reg <= last5_reg;
            val6_reg  <= val_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (en) begin
                v1_reg <= take;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
                v6_reg <= v5_reg;
            end
        end
    end

    assign out_valid  = v6_reg;
    assign elem_index = idx6_reg;
    assign value_bits = val6_reg;
    assign run_last   = last6_reg;

    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (head_valid && head.emit[0] && head.emit[1]))
        else $error("second element pending without its queue entry");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(value_bits)))
        else $error("stalled result changed");

endmodule
